>>> hdl/pidvdt_pkg.sv
package pidvdt_pkg;

    localparam int RATE_W     = 16;
    localparam int MS_W       = 16;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int ERR_W   = 17;
    localparam int DIFF_W  = 18;
    localparam int EMAG_W  = 16;
    localparam int DMAG_W  = 17;
    localparam int DNUM_W  = 27;
    localparam int INTEG_W = 48;
    localparam int IPROD_W = INTEG_W + GAIN_W;
    localparam int SUM_W   = 57;
    localparam int DRIVE_W = 32;
    localparam int KDIV_W  = 10;
    localparam int KDIG_W  = 2;

    localparam logic [KDIV_W-1:0] MS_PER_S = 10'd1000;

    localparam logic [RATE_W-1:0] TARGET_RST     = 16'h0000;
    localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = 16'd128;
    localparam logic [GAIN_W-1:0] GAIN_INTEG_RST = 16'd51;
    localparam logic [GAIN_W-1:0] GAIN_DERIV_RST = 16'd26;

    localparam logic [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    localparam logic [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
    localparam logic [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_RATE = 2'd0,
        CFG_GAIN_PROP   = 2'd1,
        CFG_GAIN_INTEG  = 2'd2,
        CFG_GAIN_DERIV  = 2'd3
    } t_cfg_reg;

endpackage

>>> hdl/pidvdt_mul.sv
module pidvdt_mul #(
    parameter int A_W = 16,
    parameter int B_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [A_W-1:0]   i_a,
    input  logic [B_W-1:0]   i_b,
    output logic [A_W+B_W-1:0] o_prod,
    output logic             o_done
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [A_W-1:0]   r_a;
    logic [B_W-1:0]   r_b;
    logic [P_W-1:0]   r_acc;
    logic [P_W-1:0]   n_acc;

    // Multiplier bits are taken most significant first, one per cycle.
    always_comb begin
        n_acc = {r_acc[P_W-2:0], 1'b0} + (r_b[B_W-1] ? P_W'(r_a) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(B_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_cnt != '0) begin
            r_acc <= n_acc;
            r_b   <= {r_b[B_W-2:0], 1'b0};
        end
    end

    assign o_prod = r_acc;
    assign o_done = (r_cnt == '0);

endmodule

>>> hdl/pidvdt_div.sv
module pidvdt_div #(
    parameter int N_W   = 27,
    parameter int D_W   = 16,
    parameter int DIG_W = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic [N_W-1:0] o_quo,
    output logic           o_done
);

    localparam int STEPS = N_W / DIG_W;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [N_W-1:0]   r_num;
    logic [D_W-1:0]   r_den;
    logic [D_W-1:0]   r_rem;
    logic [N_W-1:0]   n_num;
    logic [D_W-1:0]   n_rem;
    logic [D_W:0]     step_wide;

    // Restoring division: the dividend shifts out at the top while the
    // quotient bits shift in at the bottom of the same register.
    always_comb begin
        n_rem     = r_rem;
        n_num     = r_num;
        step_wide = '0;
        for (int k = 0; k < DIG_W; k++) begin
            step_wide = {n_rem, n_num[N_W-1]};
            n_num     = {n_num[N_W-2:0], 1'b0};
            if (step_wide >= {1'b0, r_den}) begin
                step_wide = step_wide - {1'b0, r_den};
                n_num[0]  = 1'b1;
            end
            n_rem = step_wide[D_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_quo  = r_num;
    assign o_done = (r_cnt == '0);

endmodule

>>> hdl/pid_controller_variable_dt.sv
// PID rate controller with a variable sample interval. Each input transfer
// carries a signed gyro rate sample and the milliseconds since the previous
// sample; each one yields exactly one result transfer holding the saturated
// 32-bit drive and two flags. The block works on one item at a time, and once
// an item's result appears at the output register, the next item may be
// transferred in while the result waits. The work is done by the shift-and-add
// multipliers, which consume one gain or interval bit per cycle, and by the
// divider that divides the integral term by 1000 two quotient bits per cycle
// over a 64-bit product; the derivative divider runs alongside the first two
// multiplier passes. Gains and the setpoint are written through the plain
// write port and should only be changed while no item is in flight.
module pid_controller_variable_dt (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pidvdt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pidvdt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [pidvdt_pkg::RATE_W-1:0] i_rate_sample,
    input  logic [pidvdt_pkg::MS_W-1:0]        i_elapsed_ms,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [pidvdt_pkg::DRIVE_W-1:0] o_drive,
    output logic                               o_drive_saturated,
    output logic                               o_zero_interval
);

    localparam int ERR_W   = pidvdt_pkg::ERR_W;
    localparam int DIFF_W  = pidvdt_pkg::DIFF_W;
    localparam int EMAG_W  = pidvdt_pkg::EMAG_W;
    localparam int DMAG_W  = pidvdt_pkg::DMAG_W;
    localparam int DNUM_W  = pidvdt_pkg::DNUM_W;
    localparam int GAIN_W  = pidvdt_pkg::GAIN_W;
    localparam int MS_W    = pidvdt_pkg::MS_W;
    localparam int INTEG_W = pidvdt_pkg::INTEG_W;
    localparam int IPROD_W = pidvdt_pkg::IPROD_W;
    localparam int SUM_W   = pidvdt_pkg::SUM_W;
    localparam int DRIVE_W = pidvdt_pkg::DRIVE_W;
    localparam int EPROD_W = EMAG_W + MS_W;
    localparam int PPROD_W = EMAG_W + GAIN_W;
    localparam int DPROD_W = DNUM_W + GAIN_W;
    localparam int Q_W     = SUM_W - 8;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_MUL1, S_INTEG, S_IABS, S_MUL2, S_DIVK, S_SUM1, S_SUM2, S_SAT
    } t_state;

    t_state r_state;

    logic [pidvdt_pkg::RATE_W-1:0] r_target_rate;
    logic [GAIN_W-1:0]  r_gain_prop;
    logic [GAIN_W-1:0]  r_gain_integ;
    logic [GAIN_W-1:0]  r_gain_deriv;

    logic [INTEG_W-1:0] r_integ;
    logic [ERR_W-1:0]   r_prev;
    logic [ERR_W-1:0]   r_err;
    logic [MS_W-1:0]    r_ms;
    logic               r_zero;
    logic               r_e_neg;
    logic               r_d_neg;
    logic               r_i_neg;
    logic [SUM_W-1:0]   r_sum;

    logic               r_out_valid;
    logic [DRIVE_W-1:0] r_drive;
    logic               r_drive_sat;
    logic               r_zero_int;

    logic [ERR_W-1:0]   n_err;
    logic [DIFF_W-1:0]  diff;
    logic [ERR_W-1:0]   err_neg;
    logic [DIFF_W-1:0]  diff_neg;
    logic [EMAG_W-1:0]  e_mag;
    logic [DMAG_W-1:0]  d_mag;
    logic [DNUM_W-1:0]  d_num;
    logic [EPROD_W+1:0] ems_term;
    logic [INTEG_W:0]   integ_sum;
    logic [INTEG_W-1:0] n_integ;
    logic [INTEG_W-1:0] i_mag;
    logic [SUM_W-1:0]   p_term;
    logic [SUM_W-1:0]   i_term;
    logic [SUM_W-1:0]   d_term;
    logic [Q_W-1:0]     q;
    logic               n_sat;
    logic [DRIVE_W-1:0] n_drive;
    logic               out_free;

    logic               start1;
    logic               start2;
    logic               start3;

    logic [EPROD_W-1:0] p_ems;
    logic [PPROD_W-1:0] p_kp;
    logic [IPROD_W-1:0] p_ki;
    logic [DPROD_W-1:0] p_kd;
    logic [DNUM_W-1:0]  q_d;
    logic [IPROD_W-1:0] q_k;
    logic               ems_done;
    logic               kp_done;
    logic               ki_done;
    logic               kd_done;
    logic               dd_done;
    logic               dk_done;

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_drive           = r_drive;
    assign o_drive_saturated = r_drive_sat;
    assign o_zero_interval   = r_zero_int;

    assign start1   = (r_state == S_PREP);
    assign start2   = (r_state == S_IABS);
    assign start3   = (r_state == S_MUL2) && ki_done && dd_done;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_err    = {r_target_rate[pidvdt_pkg::RATE_W-1], r_target_rate}
                 - {i_rate_sample[pidvdt_pkg::RATE_W-1], i_rate_sample};
        diff     = {r_err[ERR_W-1], r_err} - {r_prev[ERR_W-1], r_prev};
        err_neg  = -r_err;
        diff_neg = -diff;
        e_mag    = r_err[ERR_W-1] ? err_neg[EMAG_W-1:0] : r_err[EMAG_W-1:0];
        d_mag    = diff[DIFF_W-1] ? diff_neg[DMAG_W-1:0] : diff[DMAG_W-1:0];
        // Multiply by 1000 as 1024 - 16 - 8.
        d_num    = (DNUM_W'(d_mag) << 10) - (DNUM_W'(d_mag) << 4) - (DNUM_W'(d_mag) << 3);

        ems_term  = r_e_neg ? -{2'b00, p_ems} : {2'b00, p_ems};
        integ_sum = {r_integ[INTEG_W-1], r_integ}
                  + {{(INTEG_W-EPROD_W-1){ems_term[EPROD_W+1]}}, ems_term};
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            n_integ = integ_sum[INTEG_W] ? pidvdt_pkg::INTEG_MIN : pidvdt_pkg::INTEG_MAX;
        end else begin
            n_integ = integ_sum[INTEG_W-1:0];
        end
        i_mag = r_integ[INTEG_W-1] ? -r_integ : r_integ;

        p_term = r_e_neg ? -SUM_W'(p_kp) : SUM_W'(p_kp);
        i_term = r_i_neg ? -q_k[SUM_W-1:0] : q_k[SUM_W-1:0];
        d_term = r_d_neg ? -SUM_W'(p_kd) : SUM_W'(p_kd);

        q     = r_sum[SUM_W-1:8];
        n_sat = !((&q[Q_W-1:DRIVE_W-1]) || !(|q[Q_W-1:DRIVE_W-1]));
        if (n_sat) begin
            n_drive = q[Q_W-1] ? pidvdt_pkg::DRIVE_MIN : pidvdt_pkg::DRIVE_MAX;
        end else begin
            n_drive = q[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_rate <= pidvdt_pkg::TARGET_RST;
            r_gain_prop   <= pidvdt_pkg::GAIN_PROP_RST;
            r_gain_integ  <= pidvdt_pkg::GAIN_INTEG_RST;
            r_gain_deriv  <= pidvdt_pkg::GAIN_DERIV_RST;
        end else if (i_cfg_we) begin
            case (pidvdt_pkg::t_cfg_reg'(i_cfg_index))
                pidvdt_pkg::CFG_TARGET_RATE: begin
                    r_target_rate <= i_cfg_data;
                end
                pidvdt_pkg::CFG_GAIN_PROP: begin
                    r_gain_prop <= i_cfg_data;
                end
                pidvdt_pkg::CFG_GAIN_INTEG: begin
                    r_gain_integ <= i_cfg_data;
                end
                pidvdt_pkg::CFG_GAIN_DERIV: begin
                    r_gain_deriv <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_integ     <= '0;
            r_prev      <= '0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_SAT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_prev  <= r_err;
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    if (ems_done && kp_done) begin
                        r_state <= S_INTEG;
                    end
                end
                S_INTEG: begin
                    r_integ <= n_integ;
                    r_state <= S_IABS;
                end
                S_IABS: begin
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    if (ki_done && dd_done) begin
                        r_state <= S_DIVK;
                    end
                end
                S_DIVK: begin
                    if (dk_done && kd_done) begin
                        r_state <= S_SUM1;
                    end
                end
                S_SUM1: begin
                    r_state <= S_SUM2;
                end
                S_SUM2: begin
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_drive     <= n_drive;
                        r_drive_sat <= n_sat;
                        r_zero_int  <= r_zero;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_err  <= n_err;
            r_ms   <= i_elapsed_ms;
            r_zero <= (i_elapsed_ms == '0);
        end
        if (r_state == S_PREP) begin
            r_e_neg <= r_err[ERR_W-1];
            r_d_neg <= diff[DIFF_W-1];
        end
        if (r_state == S_IABS) begin
            r_i_neg <= r_integ[INTEG_W-1];
        end
        if (r_state == S_SUM1) begin
            r_sum <= p_term + i_term;
        end
        if (r_state == S_SUM2) begin
            r_sum <= r_sum + d_term;
        end
    end

    pidvdt_mul #(.A_W(EMAG_W), .B_W(MS_W)) u_mul_ems (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start1),
        .i_a     (e_mag),
        .i_b     (r_ms),
        .o_prod  (p_ems),
        .o_done  (ems_done)
    );

    pidvdt_mul #(.A_W(EMAG_W), .B_W(GAIN_W)) u_mul_kp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start1),
        .i_a     (e_mag),
        .i_b     (r_gain_prop),
        .o_prod  (p_kp),
        .o_done  (kp_done)
    );

    pidvdt_div #(.N_W(DNUM_W), .D_W(MS_W), .DIG_W(1)) u_div_d (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start1),
        .i_num   (d_num),
        .i_den   (r_ms),
        .o_quo   (q_d),
        .o_done  (dd_done)
    );

    pidvdt_mul #(.A_W(INTEG_W), .B_W(GAIN_W)) u_mul_ki (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start2),
        .i_a     (i_mag),
        .i_b     (r_gain_integ),
        .o_prod  (p_ki),
        .o_done  (ki_done)
    );

    pidvdt_div #(
        .N_W   (IPROD_W),
        .D_W   (pidvdt_pkg::KDIV_W),
        .DIG_W (pidvdt_pkg::KDIG_W)
    ) u_div_k (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start3),
        .i_num   (p_ki),
        .i_den   (pidvdt_pkg::MS_PER_S),
        .o_quo   (q_k),
        .o_done  (dk_done)
    );

    pidvdt_mul #(.A_W(DNUM_W), .B_W(GAIN_W)) u_mul_kd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start3),
        .i_a     (r_zero ? '0 : q_d),
        .i_b     (r_gain_deriv),
        .o_prod  (p_kd),
        .o_done  (kd_done)
    );

endmodule

>>> hdl/pidvdt_checker.sv
module pidvdt_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic signed [pidvdt_pkg::DRIVE_W-1:0] o_drive,
    input logic                               o_drive_saturated,
    input logic                               o_zero_interval
);

    // Only one item is in flight, so an input transfer closes the input side.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while an item was in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_drive) && $stable(o_drive_saturated)
             && $stable(o_zero_interval)))
        else $error("stalled result changed before its transfer");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_drive_saturated) |->
            (o_drive == pidvdt_pkg::DRIVE_MAX || o_drive == pidvdt_pkg::DRIVE_MIN))
        else $error("saturation flagged but drive is not at a limit");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("block not idle after reset");

endmodule

bind pid_controller_variable_dt pidvdt_checker u_pidvdt_checker (.*);

>>> tb/sv/pid_controller_variable_dt_tb.sv
module pid_controller_variable_dt_tb;

    localparam int     RATE_W          = pidvdt_pkg::RATE_W;
    localparam int     MS_W            = pidvdt_pkg::MS_W;
    localparam int     GAIN_W          = pidvdt_pkg::GAIN_W;
    localparam int     CFG_IDX_W       = pidvdt_pkg::CFG_IDX_W;
    localparam int     CFG_DATA_W      = pidvdt_pkg::CFG_DATA_W;
    localparam int     INTEG_W         = pidvdt_pkg::INTEG_W;
    localparam int     DRIVE_W         = pidvdt_pkg::DRIVE_W;
    localparam int     HOLD_OFF_CYCLES = 400;
    localparam int     SETTLE_CYCLES   = 100;
    localparam int     RANDOM_ITEMS    = 1750;
    localparam int     RANDOM_PHASES   = 8;
    localparam longint MS_PER_SEC      = 1000;
    localparam longint INTEG_HI        = (longint'(1) <<< (INTEG_W - 1)) - 1;
    localparam longint INTEG_LO        = -INTEG_HI - 1;
    localparam longint DRIVE_HI        = (longint'(1) <<< (DRIVE_W - 1)) - 1;
    localparam longint DRIVE_LO        = -DRIVE_HI - 1;

    typedef struct {
        logic signed [DRIVE_W-1:0] drive;
        logic                      clipped;
        logic                      zero_dt;
    } t_pid_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [CFG_IDX_W-1:0]         i_cfg_index;
    logic [CFG_DATA_W-1:0]        i_cfg_data;
    logic                         i_in_valid;
    logic                         o_in_ready;
    logic signed [RATE_W-1:0]     i_rate_sample;
    logic [MS_W-1:0]              i_elapsed_ms;
    logic                         o_out_valid;
    logic                         i_out_ready;
    logic signed [DRIVE_W-1:0]    o_drive;
    logic                         o_drive_saturated;
    logic                         o_zero_interval;

    logic signed [RATE_W-1:0]     model_target = pidvdt_pkg::TARGET_RST;
    logic [GAIN_W-1:0]            model_kp     = pidvdt_pkg::GAIN_PROP_RST;
    logic [GAIN_W-1:0]            model_ki     = pidvdt_pkg::GAIN_INTEG_RST;
    logic [GAIN_W-1:0]            model_kd     = pidvdt_pkg::GAIN_DERIV_RST;
    longint                       integ_acc    = 0;
    longint                       last_error   = 0;
    t_pid_result                  drive_due[$];
    int                           fail_count   = 0;
    int                           burst_left   = 0;
    bit                           hold_off_req = 1'b0;

    pid_controller_variable_dt DUT (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void predict_drive(input logic signed [RATE_W-1:0] rate,
                                          input logic [MS_W-1:0] ms);
        longint      err, dt, acc, slope, total, scaled;
        t_pid_result res;
        err = longint'(model_target) - longint'(rate);
        dt  = longint'(ms);
        acc = integ_acc + err * dt;
        if (acc > INTEG_HI) acc = INTEG_HI;
        if (acc < INTEG_LO) acc = INTEG_LO;
        integ_acc = acc;
        slope = (dt == 0) ? 0 : ((err - last_error) * MS_PER_SEC) / dt;
        total = longint'(model_kp) * err
              + (longint'(model_ki) * integ_acc) / MS_PER_SEC
              + longint'(model_kd) * slope;
        scaled = total >>> 8;
        res.clipped = 1'b0;
        if (scaled > DRIVE_HI) begin
            scaled = DRIVE_HI;
            res.clipped = 1'b1;
        end
        if (scaled < DRIVE_LO) begin
            scaled = DRIVE_LO;
            res.clipped = 1'b1;
        end
        res.drive   = scaled[DRIVE_W-1:0];
        res.zero_dt = (dt == 0);
        last_error  = err;
        drive_due.push_back(res);
    endfunction

    function automatic logic [15:0] rand16();
        logic [31:0] r;
        r = $urandom();
        return r[15:0];
    endfunction

    function automatic logic signed [RATE_W-1:0] pick_rate();
        int sel, v;
        sel = $urandom_range(0, 19);
        if (sel < 12) begin
            v = int'(model_target) + int'($urandom_range(0, 1024)) - 512;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v[15:0];
        end else if (sel < 17) begin
            return rand16();
        end else if (sel == 17) begin
            return 16'sh7fff;
        end else if (sel == 18) begin
            return 16'sh8000;
        end
        return 16'sh0000;
    endfunction

    function automatic logic [MS_W-1:0] pick_ms();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return '0;
        if (sel < 4) return MS_W'($urandom_range(1, 20));
        if (sel < 8) return MS_W'($urandom_range(1, 1000));
        return rand16();
    endfunction

    function automatic logic [RATE_W-1:0] pick_target();
        int v;
        if ($urandom_range(0, 1) == 0) return rand16();
        v = int'($urandom_range(0, 400)) - 200;
        return v[15:0];
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        int sel;
        sel = $urandom_range(0, 3);
        if (sel == 0) return rand16();
        if (sel == 1) return GAIN_W'($urandom_range(0, 1023));
        if (sel == 2) return GAIN_W'($urandom_range(0, 255));
        return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hffff;
    endfunction

    // All stimulus tasks are entered and left just after a falling edge.
    task automatic wait_idle();
        i_in_valid = 1'b0;
        burst_left = 0;
        while (drive_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input pidvdt_pkg::t_cfg_reg idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            pidvdt_pkg::CFG_TARGET_RATE: model_target = val;
            pidvdt_pkg::CFG_GAIN_PROP:   model_kp     = val;
            pidvdt_pkg::CFG_GAIN_INTEG:  model_ki     = val;
            pidvdt_pkg::CFG_GAIN_DERIV:  model_kd     = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [RATE_W-1:0] target, input logic [GAIN_W-1:0] kp,
                              input logic [GAIN_W-1:0] ki, input logic [GAIN_W-1:0] kd);
        wait_idle();
        write_reg(pidvdt_pkg::CFG_TARGET_RATE, target);
        write_reg(pidvdt_pkg::CFG_GAIN_PROP, kp);
        write_reg(pidvdt_pkg::CFG_GAIN_INTEG, ki);
        write_reg(pidvdt_pkg::CFG_GAIN_DERIV, kd);
    endtask

    task automatic send_sample(input logic signed [RATE_W-1:0] rate, input logic [MS_W-1:0] ms);
        i_in_valid    = 1'b1;
        i_rate_sample = rate;
        i_elapsed_ms  = ms;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_drive(rate, ms);
        @(negedge i_clk);
    endtask

    task automatic offer_sample(input logic signed [RATE_W-1:0] rate, input logic [MS_W-1:0] ms);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 16);
            if (gap != 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
        end
        burst_left = burst_left - 1;
        send_sample(rate, ms);
    endtask

    task automatic test_reset_defaults();
        send_sample(16'sh0000, 16'h0000);
        send_sample(16'sh7fff, 16'hffff);
        send_sample(16'sh8000, 16'h0001);
        send_sample(16'sh8000, 16'h0000);
        send_sample(16'sh5555, 16'haaaa);
        send_sample(16'shaaaa, 16'h5555);
        send_sample(-16'sd1, 16'd1000);
        send_sample(16'sd1, 16'd999);
    endtask

    task automatic test_drive_clamp();
        set_config(16'h0000, 16'hffff, 16'h0000, 16'hffff);
        send_sample(16'sh8000, 16'h0001);
        send_sample(16'sh7fff, 16'h0001);
        send_sample(16'sh7fff, 16'h0000);
        send_sample(16'sh0000, 16'hffff);
        set_config(16'h8000, 16'hffff, 16'hffff, 16'h0000);
        send_sample(16'sh7fff, 16'hffff);
        send_sample(16'sh7fff, 16'hffff);
        send_sample(16'sh8000, 16'h0000);
    endtask

    task automatic test_output_hold_off();
        set_config(pidvdt_pkg::TARGET_RST, pidvdt_pkg::GAIN_PROP_RST,
                   pidvdt_pkg::GAIN_INTEG_RST, pidvdt_pkg::GAIN_DERIV_RST);
        hold_off_req = 1'b1;
        repeat (6) send_sample(pick_rate(), pick_ms());
        wait_idle();
    endtask

    task automatic test_sender_pause();
        repeat (20) offer_sample(pick_rate(), pick_ms());
        wait_idle();
        repeat (20) offer_sample(pick_rate(), pick_ms());
        wait_idle();
    endtask

    task automatic test_random_phases();
        int phase, n;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: set_config(pidvdt_pkg::TARGET_RST, pidvdt_pkg::GAIN_PROP_RST,
                              pidvdt_pkg::GAIN_INTEG_RST, pidvdt_pkg::GAIN_DERIV_RST);
                1: set_config(16'h8000, 16'h0000, 16'h0000, 16'h0000);
                2: set_config(16'h7fff, 16'hffff, 16'hffff, 16'hffff);
                default: set_config(pick_target(), pick_gain(), pick_gain(), pick_gain());
            endcase
            for (n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++) begin
                if ($urandom_range(0, 149) == 0) wait_idle();
                offer_sample(pick_rate(), pick_ms());
            end
        end
    endtask

    // The integral limit lies tens of thousands of maximal steps away, so the
    // integral is wound up hard in one direction and then driven back.
    task automatic test_integral_windup();
        set_config(16'h7fff, 16'h0000, 16'h0001, 16'h0000);
        repeat (6) send_sample(16'sh8000, 16'hffff);
        send_sample(16'sh8000, 16'h0000);
        set_config(16'h8000, 16'h0000, 16'h0001, 16'h0000);
        repeat (6) send_sample(16'sh7fff, 16'hffff);
    endtask

    always @(posedge i_clk) begin : check_result
        t_pid_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (drive_due.size() == 0) begin
                $error("drive: no result expected, actual %0d", o_drive);
                fail_count = fail_count + 1;
            end else begin
                want = drive_due.pop_front();
                if (o_drive !== want.drive) begin
                    $error("drive: expected %0d, actual %0d", want.drive, o_drive);
                    fail_count = fail_count + 1;
                end
                if (o_drive_saturated !== want.clipped) begin
                    $error("drive_saturated: expected %0b, actual %0b",
                           want.clipped, o_drive_saturated);
                    fail_count = fail_count + 1;
                end
                if (o_zero_interval !== want.zero_dt) begin
                    $error("zero_interval: expected %0b, actual %0b",
                           want.zero_dt, o_zero_interval);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    initial begin : out_ready_pattern
        int run_left;
        bit ready_now;
        run_left    = 0;
        ready_now   = 1'b0;
        i_out_ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_out_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
                run_left = 0;
            end else begin
                if (run_left == 0) begin
                    ready_now = !ready_now;
                    if (ready_now) begin
                        run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                               : $urandom_range(1, 10);
                    end else begin
                        run_left = $urandom_range(1, 12);
                    end
                end
                run_left = run_left - 1;
                i_out_ready = ready_now;
            end
        end
    end

    initial begin : watchdog
        #200000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : run_tests
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = pidvdt_pkg::CFG_TARGET_RATE;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_rate_sample = '0;
        i_elapsed_ms  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_drive_clamp();
        test_output_hold_off();
        test_sender_pause();
        test_random_phases();
        test_integral_windup();

        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
